[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the temperature lookup block.
// Clock is aclk, reset aresetn (active low) in every module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

[hdl/tlu_pkg.sv]
// Package of the thermistor temperature lookup: widths, constants, types.
// No dependencies; used by tlu_div and thermistor_temperature_lookup.
`timescale 1ns / 1ps
package tlu_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam int SMP_W    = 12;
    localparam int TIDX_W   = 7;
    localparam int TVAL_W   = 16;
    localparam int TEMP_W   = 14;
    localparam int NUM_W    = 28;
    localparam int MULA_W   = 13;
    localparam int CNT_W    = 5;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [SMP_W-1:0]  CORE_MID  = 12'h6CF;
    // x * 19 / 10 as x * (19 * 52429) >> 19, exact for the core-sensor range
    localparam logic [19:0]       CORE_RECIP = 20'd996151;
    localparam int                CORE_SHIFT = 19;
    localparam logic [TEMP_W-1:0] CORE_BASE = 14'd250;
    localparam logic [MULA_W-1:0] ADC_FULL  = 13'd4096;

    localparam logic [7:0]  TABLE_LEN_RST = 8'd128;
    localparam logic [15:0] DIV_RES1_RST  = 16'd9810;
    localparam logic [15:0] DIV_RES2_RST  = 16'd9880;
    localparam logic [7:0]  IDX_OFS_RST   = 8'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_LEN = 2'd0,
        CFG_DIV_RES1  = 2'd1,
        CFG_DIV_RES2  = 2'd2,
        CFG_IDX_OFS   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CH_THERM1 = 2'd0,
        CH_THERM2 = 2'd1,
        CH_CORE   = 2'd2,
        CH_SPARE  = 2'd3
    } channel_t;

    typedef enum logic {
        FN_WRITE   = 1'b0,
        FN_CONVERT = 1'b1
    } func_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SRCH = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hdl/thermistor_temperature_lookup.sv]
// Top level: thermistor table store, sample conversion and table search.
// Depends on tlu_pkg, tlu_div and assert_macros.svh.
//
//  channel | direction | handshake                   | content
//  s_axis  | in        | s_axis_tvalid/s_axis_tready | table write or sample to convert
//  m_axis  | out       | m_axis_tvalid/m_axis_tready | temperature and zero-sample flag
//  cfg     | in        | cfg_valid/cfg_ready         | register index and data
//
// A table write gives no result. A core-sensor result passes through MUL, which
// registers the reciprocal multiply, and FIN, which loads the output register.
// A thermistor result passes through MUL, DIV (28 divider steps, then done), SRCH
// (at most 7 probes at the default depth) and FIN, which loads the output register.
// Reset clears control state only; table contents are undefined until written.
// A new item is taken while a result waits; a stalled m_axis holds the next one in FIN.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module thermistor_temperature_lookup #(
    parameter int TABLE_DEPTH = tlu_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // adc_sample[11:0], table_index[18:12], table_value[34:19], zero fill
    input  logic [tlu_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func[0], channel[2:1]
    input  logic [tlu_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // temperature[13:0] (signed), zero fill
    output logic [tlu_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // zero_sample[0]
    output logic [tlu_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tlu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlu_pkg::CFG_DAT_W-1:0] cfg_data
);
    import tlu_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int HI_W = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic [7:0]  table_len_reg;
    logic [15:0] div_res1_reg;
    logic [15:0] div_res2_reg;
    logic [7:0]  idx_ofs_reg;

    // input fields
    logic [SMP_W-1:0]  in_sample;
    logic [TIDX_W-1:0] in_tidx;
    logic [TVAL_W-1:0] in_tval;
    func_t             in_func;
    channel_t          in_chan;

    // control and datapath
    state_t state_reg, state_next;
    logic   core_reg, core_next;
    logic   neg_reg, neg_next;
    logic   zero_reg, zero_next;
    logic [MULA_W-1:0] mul_a_reg, mul_a_next;
    logic [15:0]       mul_b_reg, mul_b_next;
    logic [SMP_W-1:0]  den_reg, den_next;
    logic [HI_W-1:0]   hi_reg, hi_next, lo_reg, lo_next, mid_reg, mid_next, len_sat;
    logic [TEMP_W-1:0] core_q_reg, core_q_next;

    logic                    m_valid_reg, m_valid_next;
    logic signed [TEMP_W-1:0] m_temp_reg, m_temp_next;
    logic                    m_zero_reg, m_zero_next;

    // table memory
    logic [TVAL_W-1:0] table_mem [TABLE_DEPTH];
    logic [TVAL_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              wr_en;
    logic [31:0]       widx_ext;

    logic                 s_xfer, out_free, div_start;
    div_status_t          div_st;
    logic [NUM_W-1:0]     quot;
    logic [NUM_W-1:0]     twice;
    logic [TEMP_W-1:0]    core_t;

    assign in_sample = s_axis_tdata[11:0];
    assign in_tidx   = s_axis_tdata[18:12];
    assign in_tval   = s_axis_tdata[34:19];
    assign in_func   = func_t'(s_axis_tuser[0]);
    assign in_chan   = channel_t'(s_axis_tuser[2:1]);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign widx_ext = 32'(in_tidx);
    assign wr_addr  = widx_ext[AW-1:0];
    assign wr_en    = s_xfer && (in_func == FN_WRITE) && (widx_ext < 32'(TABLE_DEPTH));

    assign len_sat = (32'(table_len_reg) > 32'(TABLE_DEPTH)) ? HI_W'(TABLE_DEPTH)
                                                             : HI_W'(table_len_reg);

    assign div_start = (state_reg == ST_MUL) && !core_reg;

    tlu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (NUM_W'(mul_a_reg * mul_b_reg)),
        .den     (den_reg),
        .status  (div_st),
        .quot    (quot)
    );

    assign twice  = NUM_W'({rd_data_reg, 1'b0});
    assign core_t = (neg_reg ? (-core_q_reg) : core_q_reg) + CORE_BASE;

    always_comb begin
        state_next   = state_reg;
        core_next    = core_reg;
        neg_next     = neg_reg;
        zero_next    = zero_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        den_next     = den_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        core_q_next  = core_q_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_temp_next  = m_temp_reg;
        m_zero_next  = m_zero_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && in_func == FN_CONVERT) begin
                    core_next = (in_chan == CH_CORE);
                    zero_next = (in_chan != CH_CORE) && (in_sample == '0);
                    neg_next  = (in_sample > CORE_MID);
                    if (in_chan == CH_CORE) begin
                        mul_a_next = (in_sample > CORE_MID) ? MULA_W'(in_sample - CORE_MID)
                                                            : MULA_W'(CORE_MID - in_sample);
                    end else begin
                        mul_a_next = ADC_FULL - MULA_W'(in_sample);
                        mul_b_next = (in_chan == CH_THERM1) ? div_res1_reg : div_res2_reg;
                        den_next   = in_sample;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (core_reg) begin
                    core_q_next = TEMP_W'((32'(mul_a_reg) * 32'(CORE_RECIP)) >> CORE_SHIFT);
                    state_next  = ST_FIN;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    hi_next    = len_sat;
                    lo_next    = '0;
                    mid_next   = len_sat >> 1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if ((hi_reg - lo_reg) > HI_W'(1)) begin
                    if (quot <= twice) begin
                        lo_next = mid_reg;
                    end else begin
                        hi_next = mid_reg;
                    end
                    mid_next = ((hi_next - lo_next) >> 1) + lo_next;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_zero_next  = zero_reg;
                    m_temp_next  = core_reg ? core_t
                                            : (TEMP_W'(mid_reg) + TEMP_W'(idx_ofs_reg));
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign rd_addr = mid_next[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= in_tval;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        core_reg   <= core_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        den_reg    <= den_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        core_q_reg <= core_q_next;
        m_temp_reg <= m_temp_next;
        m_zero_reg <= m_zero_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_len_reg <= TABLE_LEN_RST;
            div_res1_reg  <= DIV_RES1_RST;
            div_res2_reg  <= DIV_RES2_RST;
            idx_ofs_reg   <= IDX_OFS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TABLE_LEN: table_len_reg <= cfg_data[7:0];
                CFG_DIV_RES1:  div_res1_reg  <= cfg_data;
                CFG_DIV_RES2:  div_res2_reg  <= cfg_data;
                CFG_IDX_OFS:   idx_ofs_reg   <= cfg_data[7:0];
                default:       table_len_reg <= table_len_reg;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - TEMP_W){1'b0}}, m_temp_reg};
    assign m_axis_tuser  = m_zero_reg;

    `ASSERT_CLK(a_srch_order, (state_reg == ST_SRCH) |-> (lo_reg <= hi_reg), "search bounds crossed")
    `ASSERT_CLK(a_mid_inside, ((state_reg == ST_SRCH) && ((hi_reg - lo_reg) > HI_W'(1))) |-> ((mid_reg > lo_reg) && (mid_reg < hi_reg)), "probe outside bounds")
    `ASSERT_NEVER(a_div_idle, (state_reg == ST_DIV) && !div_st.busy && !div_st.done, "divider stopped early")

endmodule

[hdl/tlu_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on tlu_pkg.
`timescale 1ns / 1ps
module tlu_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [tlu_pkg::NUM_W-1:0] num,
    input  logic [tlu_pkg::SMP_W-1:0] den,
    output tlu_pkg::div_status_t      status,
    output logic [tlu_pkg::NUM_W-1:0] quot
);
    import tlu_pkg::*;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [SMP_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SMP_W:0]   trial;
    logic             qbit;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        qbit      = (trial >= {1'b0, den});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], qbit};
            rem_next = qbit ? SMP_W'(trial - {1'b0, den}) : trial[SMP_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = quo_reg;

endmodule

[sim/thermistor_temperature_lookup_test.sv]
// Self-checking bench for thermistor_temperature_lookup: table fill, directed and
// random conversions under random stalls, checked against a local predictor.
// Depends on tlu_pkg and the thermistor_temperature_lookup RTL.
`timescale 1ns / 1ps
module thermistor_temperature_lookup_test;
    import tlu_pkg::*;

    localparam int CORE_CENTER   = 'h6CF;
    localparam int CORE_SLOPE    = 19;
    localparam int CORE_SCALE    = 10;
    localparam int CORE_OFFSET   = 250;
    localparam int ADC_SPAN      = 4096;
    localparam int TBL_DEPTH     = 128;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 50;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        func_t       fn;
        channel_t    ch;
        logic [11:0] smp;
        logic [6:0]  tidx;
        logic [15:0] tval;
        cfg_idx_t    creg;
        logic [15:0] cdata;
        bit          typed;
        int          temp;
        bit          zflag;
    } stim_row_t;

    typedef struct {
        logic [13:0] temp;
        logic        zero;
    } temp_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // predictor state
    logic [15:0]  therm_tbl [TBL_DEPTH];
    logic [7:0]   tbl_len = 8'd128;
    logic [15:0]  div_res_ch1 = 16'd9810;
    logic [15:0]  div_res_ch2 = 16'd9880;
    logic [7:0]   idx_ofs = 8'd7;

    temp_result_t pending_temps [$];
    stim_row_t    plan [$];
    int           faults = 0;
    int           cycles = 0;
    bit           calm = 1'b0;

    thermistor_temperature_lookup DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end

    function automatic temp_result_t predict_temperature(channel_t ch, logic [11:0] smp);
        temp_result_t r;
        int           core_t;
        longint       res;
        longint       twice;
        int           hi;
        int           lo;
        int           mid;
        logic [15:0]  rdiv;
        r.zero = 1'b0;
        if (ch == CH_CORE) begin
            core_t = ((CORE_CENTER - int'(smp)) * CORE_SLOPE) / CORE_SCALE + CORE_OFFSET;
            r.temp = core_t[13:0];
        end else begin
            rdiv = (ch == CH_THERM1) ? div_res_ch1 : div_res_ch2;
            if (smp == 0) begin
                res = 64'hFFFF_FFFF;
                r.zero = 1'b1;
            end else begin
                res = (longint'(ADC_SPAN - int'(smp)) * longint'(rdiv)) / longint'(smp);
            end
            hi = (int'(tbl_len) > TBL_DEPTH) ? TBL_DEPTH : int'(tbl_len);
            lo = 0;
            mid = hi / 2;
            while (hi - lo > 1) begin
                twice = longint'(therm_tbl[mid]) * 2;
                if (res <= twice) lo = mid;
                else hi = mid;
                mid = (hi - lo) / 2 + lo;
            end
            r.temp = 14'(mid + int'(idx_ofs));
        end
        return r;
    endfunction

    function automatic void add_write(logic [6:0] idx, logic [15:0] val);
        plan.push_back('{ROW_ITEM, FN_WRITE, CH_THERM1, 12'd0, idx, val,
                         CFG_TABLE_LEN, 16'd0, 1'b0, 0, 1'b0});
    endfunction

    function automatic void add_convert(channel_t ch, logic [11:0] smp);
        plan.push_back('{ROW_ITEM, FN_CONVERT, ch, smp, 7'd0, 16'd0,
                         CFG_TABLE_LEN, 16'd0, 1'b0, 0, 1'b0});
    endfunction

    function automatic void add_checked(channel_t ch, logic [11:0] smp, int temp, bit zflag);
        plan.push_back('{ROW_ITEM, FN_CONVERT, ch, smp, 7'd0, 16'd0,
                         CFG_TABLE_LEN, 16'd0, 1'b1, temp, zflag});
    endfunction

    function automatic void add_cfg(cfg_idx_t creg, logic [15:0] val);
        plan.push_back('{ROW_CFG, FN_WRITE, CH_THERM1, 12'd0, 7'd0, 16'd0,
                         creg, val, 1'b0, 0, 1'b0});
    endfunction

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_temps.size() != 0) @(posedge aclk);
    endtask

    task automatic send_item(stim_row_t row);
        temp_result_t want;
        if (!calm && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 21);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, row.tval, row.tidx, row.smp};
        s_axis_tuser  <= {row.ch, row.fn};
        do @(posedge aclk); while (!s_axis_tready);
        if (row.fn == FN_WRITE) begin
            therm_tbl[row.tidx] = row.tval;
        end else begin
            want = predict_temperature(row.ch, row.smp);
            if (row.typed) begin
                want.temp = 14'(row.temp);
                want.zero = row.zflag;
            end
            pending_temps.push_back(want);
        end
    endtask

    // only while idle: every result back, then time for a trailing table write
    task automatic cfg_write(cfg_idx_t creg, logic [15:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= creg;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (creg)
            CFG_TABLE_LEN: tbl_len = val[7:0];
            CFG_DIV_RES1:  div_res_ch1 = val;
            CFG_DIV_RES2:  div_res_ch2 = val;
            CFG_IDX_OFS:   idx_ofs = val[7:0];
        endcase
    endtask

    always @(posedge aclk) begin
        temp_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_temps.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: temperature %0d zero %0b",
                             $signed(m_axis_tdata[13:0]), m_axis_tuser[0]);
            end else begin
                want = pending_temps.pop_front();
                if (m_axis_tdata[13:0] !== want.temp || m_axis_tuser[0] !== want.zero) begin
                    faults++;
                    if (faults <= 10)
                        $display("mismatch: temperature %0d zero %0b, expected %0d zero %0b",
                                 $signed(m_axis_tdata[13:0]), m_axis_tuser[0],
                                 $signed(want.temp), want.zero);
                end
            end
        end
    end

    initial begin
        stim_row_t   row;
        logic [15:0] val;
        int          ph;
        int          k;

        // descending resistance table, every entry written before any search
        for (k = 0; k < TBL_DEPTH; k++)
            add_write(7'(k), 16'(60000 - k * 470));

        add_checked(CH_CORE, 12'd0, 3561, 1'b0);
        add_checked(CH_CORE, 12'd4095, -4218, 1'b0);
        add_checked(CH_CORE, 12'h6CF, 250, 1'b0);
        add_checked(CH_CORE, 12'h6D0, 249, 1'b0);
        add_checked(CH_THERM1, 12'd0, 7, 1'b1);
        add_checked(CH_THERM2, 12'd0, 7, 1'b1);
        add_checked(CH_SPARE, 12'd0, 7, 1'b1);
        add_convert(CH_THERM1, 12'd1);
        add_convert(CH_THERM2, 12'd4095);
        add_convert(CH_SPARE, 12'd2048);
        add_write(7'd127, 16'hFFFF);
        add_write(7'd0, 16'd0);
        add_convert(CH_THERM1, 12'd2000);
        add_cfg(CFG_TABLE_LEN, 16'd0);
        add_checked(CH_THERM1, 12'd1500, 7, 1'b0);
        add_cfg(CFG_TABLE_LEN, 16'd255);
        add_convert(CH_THERM1, 12'd4000);
        add_cfg(CFG_DIV_RES1, 16'd1);
        add_cfg(CFG_DIV_RES2, 16'hFFFF);
        add_cfg(CFG_IDX_OFS, 16'd255);
        add_cfg(CFG_TABLE_LEN, 16'd1);
        add_checked(CH_THERM1, 12'd1, 255, 1'b0);
        add_cfg(CFG_TABLE_LEN, 16'd128);
        add_convert(CH_THERM1, 12'd1);
        add_convert(CH_THERM2, 12'd1);
        add_convert(CH_THERM1, 12'd4095);
        add_cfg(CFG_IDX_OFS, 16'd0);
        add_checked(CH_THERM1, 12'd0, 0, 1'b1);
        add_convert(CH_THERM2, 12'd3000);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) cfg_write(plan[i].creg, plan[i].cdata);
            else send_item(plan[i]);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(5))
                0: val = 16'd1;
                1: val = 16'd2;
                2: val = 16'd128;
                3: val = 16'd255;
                4: val = 16'($urandom_range(3, 127));
                default: val = 16'($urandom_range(65535));
            endcase
            cfg_write(CFG_TABLE_LEN, val);
            case ($urandom_range(3))
                0: val = 16'd1;
                1: val = 16'hFFFF;
                2: val = 16'($urandom_range(1, 65535));
                default: val = 16'($urandom_range(5000, 20000));
            endcase
            cfg_write(CFG_DIV_RES1, val);
            case ($urandom_range(3))
                0: val = 16'd1;
                1: val = 16'hFFFF;
                2: val = 16'($urandom_range(1, 65535));
                default: val = 16'($urandom_range(5000, 20000));
            endcase
            cfg_write(CFG_DIV_RES2, val);
            case ($urandom_range(2))
                0: val = 16'd0;
                1: val = 16'd255;
                default: val = 16'($urandom_range(65535));
            endcase
            cfg_write(CFG_IDX_OFS, val);

            calm = (ph == 2);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 3) drain_results();
                row.kind  = ROW_ITEM;
                row.typed = 1'b0;
                row.fn    = ($urandom_range(99) < 15) ? FN_WRITE : FN_CONVERT;
                row.ch    = channel_t'($urandom_range(3));
                case ($urandom_range(19))
                    0, 1: row.smp = 12'd0;
                    2: row.smp = 12'd4095;
                    3: row.smp = 12'd1;
                    default: row.smp = 12'($urandom_range(4095));
                endcase
                row.tidx = 7'($urandom_range(127));
                row.tval = 16'($urandom_range(65535));
                send_item(row);
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
